// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros expect clk and rst_n in the scope where they are used.

`define JED_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define JED_ASSERT_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// ===== hdl/jed_pkg.sv =====
`timescale 1ns / 1ps

package jed_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] LETTER_U  = 8'h75;

    localparam logic [15:0] CP_MAX_ONE = 16'h007F;
    localparam logic [15:0] CP_MAX_TWO = 16'h07FF;
    localparam logic [7:0]  LEAD_TWO   = 8'hC0;
    localparam logic [7:0]  LEAD_THREE = 8'hE0;
    localparam logic [7:0]  CONT_MARK  = 8'h80;

    typedef enum logic [2:0] {
        PH_PLAIN = 3'd0,
        PH_ESC   = 3'd1,
        PH_HEX1  = 3'd2,
        PH_HEX2  = 3'd3,
        PH_HEX3  = 3'd4,
        PH_HEX4  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_CP   = 2'd1,
        CMD_ERR  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] data;
    } cmd_t;

    // Returns {not_hex, nibble}.
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] r;
        r = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) r = {1'b0, b[3:0]};
        if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
            r = {1'b0, b[3:0] + 4'd9};
        return r;
    endfunction

    // Returns {known, byte} for a single-letter escape.
    function automatic logic [8:0] escape_letter(input logic [7:0] b);
        logic [8:0] r;
        r = 9'h000;
        unique case (b)
            8'h5C, 8'h2F, 8'h22: r = {1'b1, b};
            8'h62:               r = {1'b1, 8'h08};
            8'h66:               r = {1'b1, 8'h0C};
            8'h6E:               r = {1'b1, 8'h0A};
            8'h72:               r = {1'b1, 8'h0D};
            8'h74:               r = {1'b1, 8'h09};
            default:             r = 9'h000;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/json_escape_decoder.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    in_byte
// output    out        out_valid/out_ready  out_byte, run_last, bad_escape
//
// A plain byte or single-letter escape passes the command queue and then the
// output register; such items stream at one per cycle unless output stalls.
// A code point expands to up to three bytes, one per cycle from the back end
// unless output stalls; input stalls only if the QUEUE_DEPTH queue is full.
// Reset returns the decoder to the plain state and empties the queue.
// A stalled output holds its item while the front end fills the queue.

module json_escape_decoder #(
    parameter int QUEUE_DEPTH = jed_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       bad_escape
);
    import jed_pkg::*;

    logic q_full, q_push, q_pop, q_valid;
    cmd_t q_cmd, q_head;

    jed_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    jed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    jed_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .bad_escape (bad_escape)
    );

endmodule

// ===== hdl/jed_front.sv =====
`timescale 1ns / 1ps

module jed_front (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   in_byte,
    input  logic         q_full,
    output logic         q_push,
    output jed_pkg::cmd_t q_cmd
);
    import jed_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [11:0] accum_reg, accum_next;
    logic        accept;
    logic [4:0]  hex;
    logic [8:0]  esc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign hex      = hex_nibble(in_byte);
    assign esc      = escape_letter(in_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PLAIN;
            accum_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_PLAIN: phase_next = (in_byte == BACKSLASH) ? PH_ESC : PH_PLAIN;
                PH_ESC:   phase_next = (in_byte == LETTER_U) ? PH_HEX1 : PH_PLAIN;
                PH_HEX1:  phase_next = hex[4] ? PH_PLAIN : PH_HEX2;
                PH_HEX2:  phase_next = hex[4] ? PH_PLAIN : PH_HEX3;
                PH_HEX3:  phase_next = hex[4] ? PH_PLAIN : PH_HEX4;
                PH_HEX4:  phase_next = PH_PLAIN;
                default:  phase_next = PH_PLAIN;
            endcase
        end
    end

    always_comb
    begin
        accum_next = accum_reg;
        if (accept)
        begin
            if (phase_reg == PH_HEX1 || phase_reg == PH_HEX2 || phase_reg == PH_HEX3)
                accum_next = hex[4] ? 12'h000 : {accum_reg[7:0], hex[3:0]};
            else
                accum_next = 12'h000;
        end
    end

    always_comb
    begin
        q_push     = 1'b0;
        q_cmd.kind = CMD_BYTE;
        q_cmd.data = {8'h00, in_byte};
        unique case (phase_reg)
            PH_PLAIN:
            begin
                q_push = accept && (in_byte != BACKSLASH);
            end
            PH_ESC:
            begin
                q_push     = accept && (in_byte != LETTER_U);
                q_cmd.kind = esc[8] ? CMD_BYTE : CMD_ERR;
                q_cmd.data = {8'h00, esc[7:0]};
            end
            PH_HEX1, PH_HEX2, PH_HEX3:
            begin
                q_push     = accept && hex[4];
                q_cmd.kind = CMD_ERR;
                q_cmd.data = 16'h0000;
            end
            PH_HEX4:
            begin
                q_push     = accept;
                q_cmd.kind = hex[4] ? CMD_ERR : CMD_CP;
                q_cmd.data = {accum_reg, hex[3:0]};
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/jed_queue.sv =====
`timescale 1ns / 1ps

module jed_queue #(
    parameter int DEPTH = jed_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jed_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output jed_pkg::cmd_t head
);
    import jed_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== hdl/jed_back.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module jed_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  jed_pkg::cmd_t q_head,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          run_last,
    output logic          bad_escape
);
    import jed_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       run_last_reg;
    logic       bad_escape_reg;
    logic       load;
    logic [1:0] last_idx;
    logic [7:0] cur_byte;
    logic       cur_last;

    assign load = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        last_idx = 2'd0;
        if (q_head.kind == CMD_CP)
        begin
            if (q_head.data > CP_MAX_TWO)
                last_idx = 2'd2;
            else if (q_head.data > CP_MAX_ONE)
                last_idx = 2'd1;
        end
    end

    always_comb
    begin
        cur_byte = q_head.data[7:0];
        case (q_head.kind)
            CMD_ERR:
                cur_byte = 8'h00;
            CMD_CP:
            begin
                if (last_idx == 2'd2)
                begin
                    case (idx_reg)
                        2'd0:    cur_byte = LEAD_THREE | {4'h0, q_head.data[15:12]};
                        2'd1:    cur_byte = CONT_MARK | {2'b00, q_head.data[11:6]};
                        default: cur_byte = CONT_MARK | {2'b00, q_head.data[5:0]};
                    endcase
                end
                else if (last_idx == 2'd1)
                begin
                    if (idx_reg == 2'd0)
                        cur_byte = LEAD_TWO | {3'b000, q_head.data[10:6]};
                    else
                        cur_byte = CONT_MARK | {2'b00, q_head.data[5:0]};
                end
            end
            default:
                cur_byte = q_head.data[7:0];
        endcase
    end

    assign cur_last = (idx_reg == last_idx);
    assign q_pop    = load && cur_last;
    assign idx_next = !load ? idx_reg : (cur_last ? 2'd0 : idx_reg + 2'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= cur_byte;
            run_last_reg   <= cur_last;
            bad_escape_reg <= (q_head.kind == CMD_ERR);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign run_last   = run_last_reg;
    assign bad_escape = bad_escape_reg;

    `JED_ASSERT_IMPLY(a_err_clean, out_valid_reg && bad_escape_reg,
        out_byte_reg == 8'h00 && run_last_reg, "error item carries data")
    `JED_ASSERT_IMPLY(a_mid_has_head, idx_reg != 2'd0, q_valid && q_head.kind == CMD_CP,
        "multi-byte expansion lost its command")
    `JED_ASSERT(a_idx_range, idx_reg != 2'd3, "byte index out of range")
    `JED_ASSERT_IMPLY(a_pop_last, q_pop,
        (idx_reg == 2'd2) || (idx_reg == last_idx), "command popped before last byte")

endmodule
